### src/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and codes of the first-fit region allocator
// Transaction payloads, table entry layout, operation and status codes.
// ----------------------------------------------------------------------------
package ffra_pkg;

	localparam int PAGE_BYTES_DEF  = 4096;
	localparam int TABLE_DEPTH_DEF = 16;

	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_POOL_BASE   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_POOL_LENGTH = 1'b1;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_CHECK   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] request_size;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic [31:0] grant_addr;
		logic        inside_allocation;
		logic [1:0]  status;
	} rsp_t;

	// one region: start address and 33-bit length
	typedef struct packed {
		logic [31:0] start;
		logic [32:0] length;
	} entry_t;

endpackage

### src/ffra_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_table: region table storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ffra_table #(
	parameter int DEPTH = ffra_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  ffra_pkg::entry_t wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output ffra_pkg::entry_t rdata
);

	ffra_pkg::entry_t mem_q [DEPTH];
	ffra_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/ffra_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_round: page rounding unit
// Rounds a byte count up to whole pages: a registered mask for power-of-two
// pages, else a pipelined reciprocal multiply, quotient-times-page and fixup.
// ----------------------------------------------------------------------------
module ffra_round #(
	parameter int PAGE_BYTES = ffra_pkg::PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] size,
	output logic        done,
	output logic [32:0] need
);

	localparam bit          PAGE_POW2 = (PAGE_BYTES & (PAGE_BYTES - 1)) == 0;
	localparam logic [32:0] PAGE_33   = 33'(PAGE_BYTES);

	logic        done_q;
	logic [32:0] need_q;

	generate
		if (PAGE_POW2) begin : g_mask
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					need_q <= ({1'b0, size} + (PAGE_33 - 33'd1)) & ~(PAGE_33 - 33'd1);
				end
			end
		end else begin : g_recip
			// floor(size * RECIP / 2^SHIFT) is the exact quotient for any 32-bit size
			localparam int          LOG_P   = $clog2(PAGE_BYTES);
			localparam int          SHIFT   = 32 + LOG_P;
			localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1)
				/ 64'(PAGE_BYTES);
			localparam logic [32:0] RECIP   = RECIP64[32:0];
			localparam logic [31:0] PAGE_32 = 32'(PAGE_BYTES);

			logic        v_s1;
			logic        v_s2;
			logic [31:0] size_s1;
			logic [64:0] prod_s1;
			logic [31:0] size_s2;
			logic [31:0] qp_s2;
			logic [31:0] quot;

			assign quot = 32'(prod_s1 >> SHIFT);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s1   <= 1'b0;
					v_s2   <= 1'b0;
					done_q <= 1'b0;
				end else begin
					v_s1   <= start;
					v_s2   <= v_s1;
					done_q <= v_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					size_s1 <= size;
					prod_s1 <= 65'(size) * 65'(RECIP);
				end
				if (v_s1) begin
					size_s2 <= size_s1;
					// quotient times page never exceeds size, so 32 bits hold it
					qp_s2   <= quot * PAGE_32;
				end
				if (v_s2) begin
					need_q <= (qp_s2 == size_s2) ? {1'b0, size_s2}
						: {1'b0, qp_s2} + PAGE_33;
				end
			end
		end
	endgenerate

	assign done = done_q;
	assign need = need_q;

endmodule

### src/first_fit_region_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator: first-fit page region allocator
// Free and allocated regions live in two compacted tables in synchronous
// RAM; a sequencer scans, updates and compacts them one entry per cycle.
// ----------------------------------------------------------------------------
//
//  channel | signals                      | direction | notes
//  --------+------------------------------+-----------+--------------------------
//  req     | req_valid, req_ready, req    | in        | operation, size, address
//  rsp     | rsp_valid, rsp_ready, rsp    | out       | one per request
//  cfg     | cfg_write, cfg_index, cfg_data| in       | pool base / length
//
//  A request holds the block from its accept to the response load. An
//  allocate first rounds its size up to whole pages; every request then
//  scans its table, pipelined on the RAM read port. A table update adds a
//  commit state, and a compaction pass when an entry leaves a table.
//  Reset and every config write rewrite free entry 0 in S_INIT, during
//  which no request is taken. The response sits in an output register, so the
//  next request is taken while the previous response waits on rsp_ready.
//
module first_fit_region_allocator #(
	parameter int PAGE_BYTES  = ffra_pkg::PAGE_BYTES_DEF,
	parameter int TABLE_DEPTH = ffra_pkg::TABLE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  ffra_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output ffra_pkg::rsp_t                   rsp,
	input  logic                             cfg_write,
	input  logic [ffra_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);

	// index into a table, and a count that can also hold the depth itself
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_ROUND  = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;
	localparam logic [2:0] S_SHIFT  = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]        state_q;
	logic [31:0]       pool_base_q;
	logic [31:0]       pool_len_q;
	logic [CW-1:0]     free_cnt_q;
	logic [CW-1:0]     used_cnt_q;

	// request context
	logic [1:0]        op_q;
	logic [31:0]       addr_q;
	logic [32:0]       need_q;

	// scan / compaction pointers
	logic [CW-1:0]     rd_idx_q;
	logic              cmp_v_q;
	logic [CW-1:0]     cmp_idx_q;
	logic [CW-1:0]     hit_idx_q;
	ffra_pkg::entry_t  ent_q;
	logic [CW-1:0]     wr_idx_q;
	logic              wv_q;
	logic              sh_used_q;

	ffra_pkg::rsp_t    res_q;
	ffra_pkg::rsp_t    rsp_q;
	logic              rsp_valid_q;

	// RAM ports
	logic              free_we, free_re, used_we, used_re;
	logic [AW-1:0]     free_waddr, free_raddr, used_waddr, used_raddr;
	ffra_pkg::entry_t  free_wdata, used_wdata, free_rdata, used_rdata;

	logic              round_start, round_done;
	logic [32:0]       round_need;

	ffra_pkg::entry_t  scan_rdata, sh_rdata;
	logic [CW-1:0]     scan_cnt, sh_cnt;
	logic              hit_cond, hit;
	logic [31:0]       addr_off;
	logic              req_acc;

	assign req_ready   = (state_q == S_IDLE);
	assign req_acc     = req_valid && req_ready;
	assign round_start = req_acc && (req.operation == ffra_pkg::OP_ALLOC);

	// allocate scans the free table, release and check the allocated one
	assign scan_rdata = (op_q == ffra_pkg::OP_ALLOC) ? free_rdata : used_rdata;
	assign scan_cnt   = (op_q == ffra_pkg::OP_ALLOC) ? free_cnt_q : used_cnt_q;
	assign sh_rdata   = sh_used_q ? used_rdata : free_rdata;
	assign sh_cnt     = sh_used_q ? used_cnt_q : free_cnt_q;

	assign addr_off = addr_q - scan_rdata.start;

	always_comb begin
		case (op_q)
			ffra_pkg::OP_ALLOC:   hit_cond = (scan_rdata.length >= need_q);
			ffra_pkg::OP_RELEASE: hit_cond = (scan_rdata.start == addr_q);
			// end of the allocation is taken without wrap, hence 33 bits
			default:              hit_cond = (addr_q >= scan_rdata.start) &&
			                                 ({1'b0, addr_off} < scan_rdata.length);
		endcase
	end

	assign hit = cmp_v_q && hit_cond;

	// RAM port control
	always_comb begin
		free_we    = 1'b0;
		free_waddr = '0;
		free_wdata = ent_q;
		free_re    = 1'b0;
		free_raddr = rd_idx_q[AW-1:0];
		used_we    = 1'b0;
		used_waddr = '0;
		used_wdata = ent_q;
		used_re    = 1'b0;
		used_raddr = rd_idx_q[AW-1:0];
		unique case (state_q)
			S_INIT: begin
				free_we    = 1'b1;
				free_wdata = '{start: pool_base_q, length: {1'b0, pool_len_q}};
			end
			S_SCAN: begin
				if (!hit && (rd_idx_q < scan_cnt)) begin
					if (op_q == ffra_pkg::OP_ALLOC) begin
						free_re = 1'b1;
					end else begin
						used_re = 1'b1;
					end
				end
			end
			S_COMMIT: begin
				if (op_q == ffra_pkg::OP_ALLOC) begin
					if (used_cnt_q < DEPTH_C) begin
						used_we    = 1'b1;
						used_waddr = used_cnt_q[AW-1:0];
						used_wdata = '{start: ent_q.start, length: need_q};
						// an emptied entry is dropped by the compaction pass instead
						if (ent_q.length != need_q) begin
							free_we    = 1'b1;
							free_waddr = hit_idx_q[AW-1:0];
							free_wdata = '{start:  ent_q.start + need_q[31:0],
							               length: ent_q.length - need_q};
						end
					end
				end else if (free_cnt_q < DEPTH_C) begin
					free_we    = 1'b1;
					free_waddr = free_cnt_q[AW-1:0];
					free_wdata = ent_q;
				end
			end
			S_SHIFT: begin
				if (sh_used_q) begin
					used_we    = wv_q;
					used_waddr = wr_idx_q[AW-1:0];
					used_wdata = sh_rdata;
					used_re    = (rd_idx_q < sh_cnt);
				end else begin
					free_we    = wv_q;
					free_waddr = wr_idx_q[AW-1:0];
					free_wdata = sh_rdata;
					free_re    = (rd_idx_q < sh_cnt);
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			pool_base_q <= '0;
			pool_len_q  <= '0;
			free_cnt_q  <= CW'(1);
			used_cnt_q  <= '0;
			rd_idx_q    <= '0;
			cmp_v_q     <= 1'b0;
			wv_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_acc) begin
						rd_idx_q <= '0;
						cmp_v_q  <= 1'b0;
						case (req.operation) inside
							ffra_pkg::OP_ALLOC: state_q <= S_ROUND;
							ffra_pkg::OP_RELEASE, ffra_pkg::OP_CHECK: state_q <= S_SCAN;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_ROUND: begin
					if (round_done) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// one read issued per cycle, each compared in the cycle after it
					if (hit) begin
						state_q <= (op_q == ffra_pkg::OP_CHECK) ? S_DONE : S_COMMIT;
					end else if (rd_idx_q < scan_cnt) begin
						rd_idx_q <= rd_idx_q + CW'(1);
						cmp_v_q  <= 1'b1;
					end else if (cmp_v_q) begin
						cmp_v_q <= 1'b0;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_COMMIT: begin
					state_q <= S_DONE;
					if (op_q == ffra_pkg::OP_ALLOC) begin
						if (used_cnt_q < DEPTH_C) begin
							used_cnt_q <= used_cnt_q + CW'(1);
							if (ent_q.length == need_q) begin
								sh_used_q <= 1'b0;
								rd_idx_q  <= hit_idx_q + CW'(1);
								wv_q      <= 1'b0;
								state_q   <= S_SHIFT;
							end
						end
					end else if (free_cnt_q < DEPTH_C) begin
						free_cnt_q <= free_cnt_q + CW'(1);
						sh_used_q  <= 1'b1;
						rd_idx_q   <= hit_idx_q + CW'(1);
						wv_q       <= 1'b0;
						state_q    <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					// move every entry behind the hit down by one
					if (rd_idx_q < sh_cnt) begin
						rd_idx_q <= rd_idx_q + CW'(1);
						wv_q     <= 1'b1;
					end else begin
						wv_q <= 1'b0;
						if (!wv_q) begin
							if (sh_used_q) begin
								used_cnt_q <= used_cnt_q - CW'(1);
							end else begin
								free_cnt_q <= free_cnt_q - CW'(1);
							end
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase

			if ((state_q == S_DONE) && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			// a pool write resets both tables; entry 0 is rewritten in S_INIT
			if (cfg_write) begin
				unique case (cfg_index)
					ffra_pkg::REG_POOL_BASE:   pool_base_q <= cfg_data;
					ffra_pkg::REG_POOL_LENGTH: pool_len_q  <= cfg_data;
					default: begin
					end
				endcase
				state_q    <= S_INIT;
				free_cnt_q <= CW'(1);
				used_cnt_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q   <= req.operation;
			addr_q <= req.address;
			res_q  <= '0;
		end
		if ((state_q == S_ROUND) && round_done) begin
			need_q <= round_need;
		end
		if (state_q == S_SCAN) begin
			if (hit) begin
				ent_q     <= scan_rdata;
				hit_idx_q <= cmp_idx_q;
				if (op_q == ffra_pkg::OP_CHECK) begin
					res_q.inside_allocation <= 1'b1;
				end
			end else if (rd_idx_q < scan_cnt) begin
				cmp_idx_q <= rd_idx_q;
			end else if (!cmp_v_q) begin
				case (op_q)
					ffra_pkg::OP_ALLOC:   res_q.status <= ffra_pkg::ST_NO_FIT;
					ffra_pkg::OP_RELEASE: res_q.status <= ffra_pkg::ST_NOTFOUND;
					default:              res_q.status <= ffra_pkg::ST_OK;
				endcase
			end
		end
		if (state_q == S_COMMIT) begin
			if (op_q == ffra_pkg::OP_ALLOC) begin
				if (used_cnt_q < DEPTH_C) begin
					res_q.grant_addr <= ent_q.start;
				end else begin
					res_q.status <= ffra_pkg::ST_FULL;
				end
			end else if (free_cnt_q >= DEPTH_C) begin
				res_q.status <= ffra_pkg::ST_FULL;
			end
		end
		if ((state_q == S_SHIFT) && wv_q) begin
			wr_idx_q <= wr_idx_q + CW'(1);
		end else if (state_q == S_COMMIT) begin
			wr_idx_q <= hit_idx_q;
		end
		if ((state_q == S_DONE) && (!rsp_valid_q || rsp_ready)) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	ffra_round #(
		.PAGE_BYTES (PAGE_BYTES)
	) u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (round_start),
		.size   (req.request_size),
		.done   (round_done),
		.need   (round_need)
	);

	ffra_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_free (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (free_wdata),
		.re    (free_re),
		.raddr (free_raddr),
		.rdata (free_rdata)
	);

	ffra_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_used (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.re    (used_re),
		.raddr (used_raddr),
		.rdata (used_rdata)
	);

endmodule
